// ----- rtl/tfj_pkg.sv -----
package tfj_pkg;

    localparam int WORD_W     = 8;
    localparam int MAX_WORDS  = 16;
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CHARS_W    = 9;
    localparam int SUM_W      = CHARS_W + 1;
    localparam int DIV_STEP_W = $clog2(WORD_W);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_LINE_WIDTH = 1'b0;

    localparam logic [WORD_W-1:0] LINE_WIDTH_RESET = 8'd80;

endpackage

// ----- rtl/tfj_div.sv -----
module tfj_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tfj_pkg::WORD_W-1:0]  dividend,
    input  logic [tfj_pkg::IDX_W-1:0]   divisor,
    output logic                        done,
    output logic [tfj_pkg::WORD_W-1:0]  quotient,
    output logic [tfj_pkg::IDX_W-1:0]   remainder
);

    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic [tfj_pkg::DIV_STEP_W-1:0]   step_reg;
    logic [tfj_pkg::DIV_STEP_W-1:0]   step_next;
    logic [tfj_pkg::WORD_W-1:0]       work_reg;
    logic [tfj_pkg::WORD_W-1:0]       work_next;
    logic [tfj_pkg::IDX_W-1:0]        rem_reg;
    logic [tfj_pkg::IDX_W-1:0]        rem_next;
    logic [tfj_pkg::IDX_W-1:0]        div_reg;
    logic [tfj_pkg::IDX_W-1:0]        div_next;
    logic [tfj_pkg::IDX_W:0]          trial;
    logic [tfj_pkg::IDX_W:0]          diff;
    logic                             fits;

    // One quotient bit per cycle, restoring form. The dividend shifts out of
    // work_reg at the top while quotient bits shift in at the bottom.
    assign trial = {rem_reg, work_reg[tfj_pkg::WORD_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            work_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[tfj_pkg::WORD_W-2:0], fits};
            rem_next  = fits ? diff[tfj_pkg::IDX_W-1:0] : trial[tfj_pkg::IDX_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == tfj_pkg::DIV_STEP_W'(tfj_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

`ifndef NO_ASSERTIONS
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider signals done while still running");
    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ----- rtl/text_full_justify.sv -----
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+--------------------------------------
// word in   | start && !busy                     | word_length, last_word
// result    | out_valid, one cycle, no stall     | out_word_length, spaces_after,
//           |                                    | line_end, text_end, too_long
// config    | psel && penable && pwrite (APB)    | paddr, pwdata -> line_width
//
// A word that only joins the current line passes through S_APPEND. Closing a line adds S_PREP,
// a divider run (eight quotient bits, then done) when two or more words are justified,
// and an S_EMIT step per buffered word as results are walked out; an overlong word is then
// shown on its own. The worst item flushes fifteen words and then ends the text.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// Results are registered and shown for a single cycle: the receiver cannot stall them.
module text_full_justify (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tfj_pkg::WORD_W-1:0]    word_length,
    input  logic                          last_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfj_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfj_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfj_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic                          out_valid,
    output logic [tfj_pkg::WORD_W-1:0]    out_word_length,
    output logic [tfj_pkg::WORD_W-1:0]    spaces_after,
    output logic                          line_end,
    output logic                          text_end,
    output logic                          too_long
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPEND = 5'b00010,
        S_PREP   = 5'b00100,
        S_DIV    = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    // S_LONG is folded into the after-flush action to keep the walk in one place.
    typedef enum logic [2:0] {
        AFTER_NONE   = 3'b001,
        AFTER_APPEND = 3'b010,
        AFTER_LONG   = 3'b100
    } after_t;

    state_t                           state_reg;
    state_t                           state_next;
    after_t                           after_reg;
    after_t                           after_next;
    logic                             left_reg;
    logic                             left_next;
    logic                             te_reg;
    logic                             te_next;
    logic                             long_pend_reg;
    logic                             long_pend_next;
    logic [tfj_pkg::CNT_W-1:0]        count_reg;
    logic [tfj_pkg::CNT_W-1:0]        count_next;
    logic [tfj_pkg::CHARS_W-1:0]      chars_reg;
    logic [tfj_pkg::CHARS_W-1:0]      chars_next;
    logic [tfj_pkg::IDX_W-1:0]        idx_reg;
    logic [tfj_pkg::IDX_W-1:0]        idx_next;
    logic [tfj_pkg::WORD_W-1:0]       line_width_reg;
    logic [tfj_pkg::WORD_W-1:0]       wl_reg;
    logic                             last_reg;
    logic [tfj_pkg::WORD_W-1:0]       spare_reg;
    logic [tfj_pkg::WORD_W-1:0]       lengths_reg [tfj_pkg::MAX_WORDS];

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [tfj_pkg::WORD_W-1:0]       out_len_reg;
    logic [tfj_pkg::WORD_W-1:0]       out_len_next;
    logic [tfj_pkg::WORD_W-1:0]       sp_reg;
    logic [tfj_pkg::WORD_W-1:0]       sp_next;
    logic                             le_reg;
    logic                             le_next;
    logic                             tend_reg;
    logic                             tend_next;
    logic                             tl_reg;
    logic                             tl_next;

    logic                             accept;
    logic                             append_en;
    logic                             cfg_wr;
    logic [tfj_pkg::SUM_W-1:0]        fit_sum;
    logic                             overlong;
    logic [tfj_pkg::CHARS_W-1:0]      width_ext;
    logic [tfj_pkg::WORD_W-1:0]       spare_calc;
    logic [tfj_pkg::CNT_W-1:0]        count_m1;
    logic [tfj_pkg::CNT_W-1:0]        count_p1;
    logic [tfj_pkg::WORD_W-1:0]       trail;
    logic                             last_in_line;
    logic [tfj_pkg::WORD_W-1:0]       cur_len;
    logic [tfj_pkg::WORD_W-1:0]       sp_calc;
    logic                             div_start;
    logic                             div_done;
    logic [tfj_pkg::WORD_W-1:0]       div_q;
    logic [tfj_pkg::IDX_W-1:0]        div_r;

    // The cycle that prepares an overlong word to be shown on its own still counts as busy.
    assign busy    = (state_reg != S_IDLE) || long_pend_reg;
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == tfj_pkg::REG_LINE_WIDTH);
    assign prdata  = (paddr[2] == tfj_pkg::REG_LINE_WIDTH) ?
                     tfj_pkg::PDATA_W'(line_width_reg) : '0;

    assign fit_sum   = tfj_pkg::SUM_W'(chars_reg) + tfj_pkg::SUM_W'(word_length)
                     + tfj_pkg::SUM_W'(count_reg);
    assign overlong  = (word_length > line_width_reg);
    assign width_ext = tfj_pkg::CHARS_W'(line_width_reg);
    assign spare_calc = (width_ext > chars_reg) ?
                        tfj_pkg::WORD_W'(width_ext - chars_reg) : '0;

    assign count_m1     = count_reg - 1'b1;
    assign count_p1     = count_reg + 1'b1;
    assign trail        = (spare_reg > tfj_pkg::WORD_W'(count_m1)) ?
                          (spare_reg - tfj_pkg::WORD_W'(count_m1)) : '0;
    assign last_in_line = (tfj_pkg::CNT_W'(idx_reg) == count_m1);
    assign cur_len      = lengths_reg[idx_reg];
    assign div_start    = (state_reg == S_PREP) && !left_reg && (count_reg > 1);
    assign append_en    = (state_reg == S_APPEND);

    // Spaces after the current word of a line being closed.
    always_comb
    begin
        if (count_reg == 1)
        begin
            sp_calc = spare_reg;
        end
        else if (left_reg)
        begin
            sp_calc = last_in_line ? trail : tfj_pkg::WORD_W'(1);
        end
        else if (last_in_line)
        begin
            sp_calc = '0;
        end
        else
        begin
            // The leftmost gaps take the remainder, one extra space each.
            sp_calc = div_q + ((idx_reg < div_r) ? 1'b1 : 1'b0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        left_next      = left_reg;
        te_next        = te_reg;
        long_pend_next = long_pend_reg;
        count_next     = count_reg;
        chars_next     = chars_reg;
        idx_next       = idx_reg;
        out_valid_next = 1'b0;
        out_len_next   = out_len_reg;
        sp_next        = sp_reg;
        le_next        = le_reg;
        tend_next      = tend_reg;
        tl_next        = tl_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (long_pend_reg)
                begin
                    // An overlong word goes out alone once the buffer is flushed.
                    long_pend_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_len_next   = wl_reg;
                    sp_next        = '0;
                    le_next        = 1'b1;
                    tend_next      = last_reg;
                    tl_next        = 1'b1;
                end
                else if (accept)
                begin
                    left_next = 1'b0;
                    te_next   = 1'b0;
                    idx_next  = '0;
                    if (overlong)
                    begin
                        if (count_reg != 0)
                        begin
                            after_next = AFTER_LONG;
                            state_next = S_PREP;
                        end
                        else
                        begin
                            long_pend_next = 1'b1;
                        end
                    end
                    else if ((count_reg != 0) &&
                             (fit_sum > tfj_pkg::SUM_W'(line_width_reg)))
                    begin
                        after_next = AFTER_APPEND;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                count_next = count_p1;
                chars_next = chars_reg + tfj_pkg::CHARS_W'(wl_reg);
                idx_next   = '0;
                after_next = AFTER_NONE;
                if (last_reg)
                begin
                    left_next  = 1'b1;
                    te_next    = 1'b1;
                    state_next = S_PREP;
                end
                else if (count_p1 == tfj_pkg::CNT_W'(tfj_pkg::MAX_WORDS))
                begin
                    left_next  = 1'b0;
                    te_next    = 1'b0;
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREP:
            begin
                state_next = div_start ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_len_next   = cur_len;
                sp_next        = sp_calc;
                le_next        = last_in_line;
                tend_next      = last_in_line && te_reg;
                tl_next        = 1'b0;
                if (last_in_line)
                begin
                    count_next = '0;
                    chars_next = '0;
                    idx_next   = '0;
                    case (after_reg)
                        AFTER_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        AFTER_LONG:
                        begin
                            long_pend_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            after_reg      <= AFTER_NONE;
            left_reg       <= 1'b0;
            te_reg         <= 1'b0;
            long_pend_reg  <= 1'b0;
            count_reg      <= '0;
            chars_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            line_width_reg <= tfj_pkg::LINE_WIDTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            left_reg      <= left_next;
            te_reg        <= te_next;
            long_pend_reg <= long_pend_next;
            count_reg     <= count_next;
            chars_reg     <= chars_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                line_width_reg <= pwdata[tfj_pkg::WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wl_reg   <= word_length;
            last_reg <= last_word;
        end
        if (state_reg == S_PREP)
        begin
            spare_reg <= spare_calc;
        end
        if (append_en)
        begin
            lengths_reg[count_reg[tfj_pkg::IDX_W-1:0]] <= wl_reg;
        end
        out_len_reg <= out_len_next;
        sp_reg      <= sp_next;
        le_reg      <= le_next;
        tend_reg    <= tend_next;
        tl_reg      <= tl_next;
    end

    tfj_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (spare_calc),
        .divisor   (count_m1[tfj_pkg::IDX_W-1:0]),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_valid       = out_valid_reg;
    assign out_word_length = out_len_reg;
    assign spaces_after    = sp_reg;
    assign line_end        = le_reg;
    assign text_end        = tend_reg;
    assign too_long        = tl_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tfj_pkg::CNT_W'(tfj_pkg::MAX_WORDS))
        else $error("word buffer count beyond its depth");
    a_idle_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg < tfj_pkg::CNT_W'(tfj_pkg::MAX_WORDS)))
        else $error("full line left open while idle");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (count_reg != 0))
        else $error("line walk over an empty buffer");
    a_text_end_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tend_reg) |-> le_reg)
        else $error("end of text without end of line");
    a_long_word_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tl_reg) |-> (le_reg && sp_reg == '0))
        else $error("overlong word not placed alone");
`endif

endmodule
